/* sv/jdcd_pkg.sv */
`default_nettype none

package jdcd_pkg;

    localparam int DAY_W   = 23;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int DOY_W   = 9;

    // First day number that is read in the Gregorian calendar.
    localparam int GREG_START   = 2299161;
    // alpha = floor((4z - ALPHA_OFFSET) / ALPHA_DIV)
    localparam int ALPHA_OFFSET = 7468865;
    localparam int ALPHA_DIV    = 146097;
    localparam int B_OFFSET     = 1524;
    // C = floor((20B - C_OFFSET) / C_DIV)
    localparam int C_OFFSET     = 2442;
    localparam int C_DIV        = 7305;
    // D = floor(D_SCALE * C / 4)
    localparam int D_SCALE      = 1461;
    // E = floor(E_SCALE * (B - D) / E_DIV)
    localparam int E_SCALE      = 10000;
    localparam int E_DIV        = 306001;
    localparam int YEAR_BASE    = 4716;
    // Shifts the year to a positive value by a multiple of 400 for the leap test.
    localparam int LEAP_SHIFT   = 8000 - YEAR_BASE;
    localparam int CENTURY      = 100;

    localparam int MONTH_FEB    = 2;
    localparam int E_WRAP       = 14;

    // floor(30.6001 * e)
    function automatic logic [8:0] e_offset(input logic [3:0] e);
        logic [8:0] r;
        begin
            case (e)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd30;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd91;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd183;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd244;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd336;
                4'd12:   r = 9'd367;
                4'd13:   r = 9'd397;
                4'd14:   r = 9'd428;
                4'd15:   r = 9'd459;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // floor(275 * month / 9) - 30
    function automatic logic [8:0] doy_base(input logic [3:0] month);
        logic [8:0] r;
        begin
            case (month)
                4'd1:    r = 9'd0;
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd61;
                4'd4:    r = 9'd92;
                4'd5:    r = 9'd122;
                4'd6:    r = 9'd153;
                4'd7:    r = 9'd183;
                4'd8:    r = 9'd214;
                4'd9:    r = 9'd245;
                4'd10:   r = 9'd275;
                4'd11:   r = 9'd306;
                4'd12:   r = 9'd336;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/julian_day_to_calendar_date_core.sv */
// Whole Julian day number to calendar date, fully pipelined.
// Throughput: one day number per cycle; busy is always low.
// The receiver cannot stall, so every stage advances on every cycle.
// rst_n clears all valid bits asynchronously; no result is pending after reset.
`default_nettype none

module julian_day_to_calendar_date_core
    import jdcd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [DAY_W-1:0]         day_number,
    output logic                          done,
    output logic [DOY_W-1:0]              day_of_year,
    output logic signed [YEAR_W-1:0]      calendar_year,
    output logic [MONTH_W-1:0]            calendar_month,
    output logic [DOM_W-1:0]              day_of_month
);

    // Stage 0: input register.
    logic              v0_reg;
    logic [22:0]       z0_reg;
    logic [24:0]       n1_reg;

    // Alpha divider.
    logic              va;
    logic [7:0]        alpha;
    logic [22:0]       za;

    // Stages 1 and 2: B and the numerator of C.
    logic              v1_reg, v2_reg;
    logic [23:0]       b1_reg, b2_reg;
    logic [27:0]       n2_reg;
    logic [23:0]       b_next;
    logic              greg;

    // C divider.
    logic              vc;
    logic [15:0]       c_full;
    logic [23:0]       bc;

    // Stages 3 to 5: D, B - D and the numerator of E.
    logic              v3_reg, v4_reg, v5_reg;
    logic [14:0]       c3_reg, c4_reg, c5_reg;
    logic [23:0]       b3_reg;
    logic [25:0]       dprod_reg;
    logic [8:0]        x4_reg, x5_reg;
    logic [22:0]       n3_reg;

    // E divider.
    logic              ve;
    logic [4:0]        e_full;
    logic [23:0]       se;
    logic [8:0]        xe;
    logic [14:0]       ce;
    logic [3:0]        e;

    // Stage 6: month, day of month, year.
    logic              v6_reg;
    logic [14:0]       y6_reg;
    logic [4:0]        dom6_reg;
    logic [3:0]        month6_reg;
    logic [15:0]       year6_reg;
    logic [3:0]        month_next;
    logic              early;

    // Century divider for the leap test.
    logic              vy;
    logic [8:0]        q100;
    logic [39:0]       sy;
    logic [14:0]       yy;
    logic [4:0]        domy;
    logic [3:0]        monthy;
    logic [15:0]       yeary;
    logic [15:0]       cent_full;
    logic              leap;
    logic [8:0]        doy_next;

    // Output registers.
    logic              done_reg;
    logic [8:0]        doy_reg;
    logic [15:0]       year_reg;
    logic [3:0]        month_reg;
    logic [4:0]        dom_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start & ~busy;
            v1_reg   <= va;
            v2_reg   <= v1_reg;
            v3_reg   <= vc;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= ve;
            done_reg <= vy;
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg <= day_number;
        n1_reg <= {day_number, 2'b00} - 25'(ALPHA_OFFSET);
    end

    jdcd_cdiv #(
        .NUM_W   (25),
        .DIVISOR (ALPHA_DIV),
        .SIDE_W  (23)
    ) u_div_alpha (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .num       (n1_reg),
        .side_in   (z0_reg),
        .out_valid (va),
        .quo       (alpha),
        .side_out  (za)
    );

    // Before the reform the alpha term is dropped and the Julian calendar applies.
    assign greg   = (za >= 23'(GREG_START));
    assign b_next = 24'(za) + 24'(B_OFFSET)
                  + (greg ? (24'(alpha) + 24'd1 - 24'(alpha >> 2)) : 24'd0);

    always_ff @(posedge clk)
    begin
        b1_reg <= b_next;
        b2_reg <= b1_reg;
        n2_reg <= {b1_reg, 4'b0000} + {2'b00, b1_reg, 2'b00} - 28'(C_OFFSET);
    end

    jdcd_cdiv #(
        .NUM_W   (28),
        .DIVISOR (C_DIV),
        .SIDE_W  (24)
    ) u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .num       (n2_reg),
        .side_in   (b2_reg),
        .out_valid (vc),
        .quo       (c_full),
        .side_out  (bc)
    );

    always_ff @(posedge clk)
    begin
        dprod_reg <= 26'(c_full[14:0]) * 26'(D_SCALE);
        c3_reg    <= c_full[14:0];
        b3_reg    <= bc;
        x4_reg    <= 9'(b3_reg - dprod_reg[25:2]);
        c4_reg    <= c3_reg;
        n3_reg    <= 23'(x4_reg) * 23'(E_SCALE);
        x5_reg    <= x4_reg;
        c5_reg    <= c4_reg;
    end

    jdcd_cdiv #(
        .NUM_W   (23),
        .DIVISOR (E_DIV),
        .SIDE_W  (24)
    ) u_div_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (n3_reg),
        .side_in   ({x5_reg, c5_reg}),
        .out_valid (ve),
        .quo       (e_full),
        .side_out  (se)
    );

    assign e          = e_full[3:0];
    assign xe         = se[23:15];
    assign ce         = se[14:0];
    assign month_next = (e < 4'(E_WRAP)) ? (e - 4'd1) : (e - 4'(E_WRAP - 1));
    // January and February belong to the year after the one that C counts from.
    assign early      = (month_next <= 4'(MONTH_FEB));

    always_ff @(posedge clk)
    begin
        dom6_reg   <= 5'(xe - e_offset(e));
        month6_reg <= month_next;
        year6_reg  <= 16'(ce) - 16'(YEAR_BASE) + 16'(early);
        y6_reg     <= ce + 15'(LEAP_SHIFT) + 15'(early);
    end

    jdcd_cdiv #(
        .NUM_W   (15),
        .DIVISOR (CENTURY),
        .SIDE_W  (40)
    ) u_div_cent (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (y6_reg),
        .side_in   ({dom6_reg, month6_reg, year6_reg, y6_reg}),
        .out_valid (vy),
        .quo       (q100),
        .side_out  (sy)
    );

    assign domy      = sy[39:35];
    assign monthy    = sy[34:31];
    assign yeary     = sy[30:15];
    assign yy        = sy[14:0];
    assign cent_full = 16'(q100) * 16'(CENTURY);

    // A century year is a leap year only when its century count is a multiple of four.
    assign leap = (cent_full[14:0] == yy) ? (q100[1:0] == 2'b00) : (yy[1:0] == 2'b00);

    always_comb
    begin
        doy_next = doy_base(monthy) + 9'(domy);
        if (monthy > 4'(MONTH_FEB))
        begin
            doy_next = doy_next - (leap ? 9'd1 : 9'd2);
        end
    end

    always_ff @(posedge clk)
    begin
        doy_reg   <= doy_next;
        year_reg  <= yeary;
        month_reg <= monthy;
        dom_reg   <= domy;
    end

    assign done           = done_reg;
    assign day_of_year    = doy_reg;
    assign calendar_year  = $signed(year_reg);
    assign calendar_month = month_reg;
    assign day_of_month   = dom_reg;

endmodule

`default_nettype wire

/* sv/jdcd_cdiv.sv */
`default_nettype none

// Floor division of an unsigned value by a constant in three stages:
// reciprocal multiply, back multiply, then one compare and correction.
// The reciprocal estimate is never more than one below the true quotient.
module jdcd_cdiv #(
    parameter int NUM_W   = 8,
    parameter int DIVISOR = 3,
    parameter int SIDE_W  = 1,
    localparam int QUO_W  = NUM_W - $clog2(DIVISOR) + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    localparam logic [QUO_W-1:0] RECIP = QUO_W'((64'd1 << NUM_W) / DIVISOR);
    localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

    logic [NUM_W+QUO_W-1:0] prod;
    logic [NUM_W+QUO_W-1:0] back;
    logic [NUM_W-1:0]       rem;

    logic                   va_reg, vb_reg, vc_reg;
    logic [QUO_W-1:0]       qa_reg, qb_reg, quo_reg;
    logic [NUM_W-1:0]       na_reg, nb_reg, qd_reg;
    logic [SIDE_W-1:0]      sa_reg, sb_reg, sc_reg;

    assign prod = {QUO_W'(0), num} * {NUM_W'(0), RECIP};
    assign back = {NUM_W'(0), qa_reg} * {QUO_W'(0), DIV_N};
    assign rem  = nb_reg - qd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg  <= prod[NUM_W+QUO_W-1:NUM_W];
        na_reg  <= num;
        sa_reg  <= side_in;
        qd_reg  <= back[NUM_W-1:0];
        qb_reg  <= qa_reg;
        nb_reg  <= na_reg;
        sb_reg  <= sa_reg;
        quo_reg <= qb_reg + QUO_W'(rem >= DIV_N);
        sc_reg  <= sb_reg;
    end

    assign out_valid = vc_reg;
    assign quo       = quo_reg;
    assign side_out  = sc_reg;

endmodule

`default_nettype wire
